// ----- hdl/ccr_pkg.sv -----
// Shared widths, codes and types for the centripetal Catmull-Rom evaluator.
// Used by every module in this folder; depends on nothing else.
package ccr_pkg;

    localparam int COORD_W = 32;
    localparam int MUL_A_W = 37;
    localparam int MUL_B_W = 33;
    localparam int PROD_W = MUL_A_W + MUL_B_W;
    localparam int SUMSQ_W = 66;
    localparam int RAD_W = 68;
    localparam int ROOT_W = RAD_W / 2;
    localparam int GAP_W = 25;
    localparam int SUM_W = GAP_W + 1;
    localparam int INNER_W = 37;
    localparam int DIVN_W = 64;
    localparam int T_W = 16;
    localparam int CFG_W = 16;
    localparam int QUOT_W = 39;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    typedef logic signed [INNER_W-1:0] inner_t;
    typedef logic signed [COORD_W-1:0] coord_t;

endpackage

// ----- hdl/ccr_mul.sv -----
// Bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle.
// Depends on ccr_pkg.
module ccr_mul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ccr_pkg::MUL_A_W-1:0]    a,
    input  logic [ccr_pkg::MUL_B_W-1:0]    b,
    output logic                           done,
    output logic [ccr_pkg::PROD_W-1:0]     prod
);
    import ccr_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);

    logic [MUL_A_W-1:0] a_reg;
    logic [MUL_A_W-1:0] hi_reg;
    logic [MUL_B_W-1:0] lo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [MUL_A_W:0]   sum;

    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MUL_B_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[MUL_A_W:1];
            lo_reg <= {sum[0], lo_reg[MUL_B_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

// ----- hdl/ccr_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on ccr_pkg.
module ccr_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ccr_pkg::RAD_W-1:0]     radicand,
    output logic                          done,
    output logic [ccr_pkg::ROOT_W-1:0]    root
);
    import ccr_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              ge;
    logic [REM_W+1:0]  rem_sub;

    assign rem_sh  = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign ge      = rem_sh >= trial;
    assign rem_sub = ge ? rem_sh - trial : rem_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_sub[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- hdl/ccr_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ccr_pkg.
module ccr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ccr_pkg::DIVN_W-1:0]    num,
    input  logic [ccr_pkg::SUM_W-1:0]     den,
    output logic                          done,
    output logic [ccr_pkg::DIVN_W-1:0]    quot
);
    import ccr_pkg::*;

    localparam int CNT_W = $clog2(DIVN_W);

    logic [DIVN_W-1:0] num_reg;
    logic [SUM_W-1:0]  den_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [SUM_W:0]    rem_sh;
    logic              ge;
    logic [SUM_W:0]    rem_sub;

    assign rem_sh  = {rem_reg, num_reg[DIVN_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = ge ? rem_sh - {1'b0, den_reg} : rem_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVN_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIVN_W-2:0], ge};
            rem_reg <= rem_sub[SUM_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

// ----- hdl/centripetal_catmull_rom_eval.sv -----
// A push transaction (tuser 0) shifts a control point into the four-point window. An evaluate
// transaction (tuser 1) returns the point at t between P1 and P2, worked out on the bit-serial
// multiplier, square root and divider that all steps share: three knot gaps of three squares
// and two roots each, one multiply for the offset s, then eighteen blends of one multiply
// and one 64-bit divide each. One item is worked on at a time.
// Depends on ccr_pkg, ccr_mul, ccr_sqrt and ccr_div.
module centripetal_catmull_rom_eval (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [111:0]             s_tdata,   // point_x, point_y, point_z, eval_t
    input  logic [0:0]               s_tuser,   // kind
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [95:0]              m_tdata,   // curve_x, curve_y, curve_z
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [ccr_pkg::CFG_W-1:0] cfg_data
);
    import ccr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_GLD0, S_GLD1, S_GSQ, S_GRT1, S_GRT2, S_OFF,
        S_BLDP, S_BLDQ, S_BMUL, S_BDIV, S_OUT
    } state_t;

    localparam logic [3:0] SRC_W0 = 4'd0;
    localparam logic [3:0] SRC_W1 = 4'd1;
    localparam logic [3:0] SRC_W2 = 4'd2;
    localparam logic [3:0] SRC_W3 = 4'd3;
    localparam logic [3:0] SRC_A1 = 4'd4;
    localparam logic [3:0] SRC_A2 = 4'd5;
    localparam logic [3:0] SRC_A3 = 4'd6;
    localparam logic [3:0] SRC_B1 = 4'd7;
    localparam logic [3:0] SRC_B2 = 4'd8;

    localparam inner_t INNER_MAX = {1'b0, {(INNER_W-1){1'b1}}};
    localparam inner_t INNER_MIN = {1'b1, {(INNER_W-1){1'b0}}};

    state_t             state_reg;
    coord_t             win_reg [3][4];
    inner_t             tmp_reg [5];
    logic [GAP_W-1:0]   gap_reg [3];
    coord_t             res_reg [3];
    logic [CFG_W-1:0]   min_gap_reg;
    logic [T_W-1:0]     t_reg;
    logic [GAP_W-1:0]   s_reg;
    logic [SUMSQ_W-1:0] sumsq_reg;
    inner_t             opa_reg;
    logic               neg_reg;
    logic [1:0]         ax_reg;
    logic [1:0]         gi_reg;
    logic [2:0]         k_reg;
    logic               out_valid_reg;
    logic [95:0]        out_data_reg;

    logic               mul_start_reg;
    logic [MUL_A_W-1:0] mul_a_reg;
    logic [MUL_B_W-1:0] mul_b_reg;
    logic               sqrt_start_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic               div_start_reg;
    logic [DIVN_W-1:0]  div_num_reg;

    logic               mul_done;
    logic [PROD_W-1:0]  prod;
    logic               sqrt_done;
    logic [ROOT_W-1:0]  root;
    logic               div_done;
    logic [DIVN_W-1:0]  quot;

    logic [3:0]         rd_sel;
    inner_t             rd_val;
    logic [3:0]         src_p;
    logic [3:0]         src_q;
    logic [SUM_W-1:0]   num_k;
    logic [SUM_W-1:0]   den_k;
    logic [SUM_W-1:0]   ga;
    logic [SUM_W-1:0]   gb;
    logic [SUM_W-1:0]   gc;
    logic [SUM_W-1:0]   sx;
    logic signed [INNER_W:0] diff;
    logic [MUL_A_W-1:0] mag;
    logic [QUOT_W-1:0]  quot_sat;
    logic signed [INNER_W+2:0] blend_sum;
    inner_t             blend_res;
    coord_t             coord_sat;
    logic [GAP_W-1:0]   min_gap;
    logic [SUMSQ_W-1:0] sumsq_next;

    ccr_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .prod  (prod)
    );

    ccr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start_reg),
        .radicand (rad_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    ccr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (den_k),
        .done  (div_done),
        .quot  (quot)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign ga = {1'b0, gap_reg[0]};
    assign gb = {1'b0, gap_reg[1]};
    assign gc = {1'b0, gap_reg[2]};
    assign sx = {1'b0, s_reg};

    always_comb
    begin
        case (k_reg)
            3'd0:
            begin
                src_p = SRC_W0; src_q = SRC_W1; num_k = ga + sx;      den_k = ga;
            end
            3'd1:
            begin
                src_p = SRC_W1; src_q = SRC_W2; num_k = sx;           den_k = gb;
            end
            3'd2:
            begin
                src_p = SRC_W3; src_q = SRC_W2; num_k = gc + gb - sx; den_k = gc;
            end
            3'd3:
            begin
                src_p = SRC_A1; src_q = SRC_A2; num_k = ga + sx;      den_k = ga + gb;
            end
            3'd4:
            begin
                src_p = SRC_A2; src_q = SRC_A3; num_k = sx;           den_k = gb + gc;
            end
            default:
            begin
                src_p = SRC_B1; src_q = SRC_B2; num_k = sx;           den_k = gb;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_GLD0:  rd_sel = {2'b00, gi_reg};
            S_GLD1:  rd_sel = {2'b00, gi_reg} + 4'd1;
            S_BLDP:  rd_sel = src_p;
            default: rd_sel = src_q;
        endcase
    end

    always_comb
    begin
        case (rd_sel)
            SRC_W0:  rd_val = INNER_W'(win_reg[ax_reg][0]);
            SRC_W1:  rd_val = INNER_W'(win_reg[ax_reg][1]);
            SRC_W2:  rd_val = INNER_W'(win_reg[ax_reg][2]);
            SRC_W3:  rd_val = INNER_W'(win_reg[ax_reg][3]);
            SRC_A1:  rd_val = tmp_reg[0];
            SRC_A2:  rd_val = tmp_reg[1];
            SRC_A3:  rd_val = tmp_reg[2];
            SRC_B1:  rd_val = tmp_reg[3];
            default: rd_val = tmp_reg[4];
        endcase
    end

    assign diff = {rd_val[INNER_W-1], rd_val} - {opa_reg[INNER_W-1], opa_reg};
    assign mag  = diff[INNER_W] ? MUL_A_W'(-diff) : MUL_A_W'(diff);

    assign sumsq_next = sumsq_reg + prod[SUMSQ_W-1:0];
    assign min_gap    = (min_gap_reg == '0) ? GAP_W'(1) : GAP_W'(min_gap_reg);

    assign quot_sat = ((|quot[DIVN_W-1:QUOT_W]) || (quot[QUOT_W-1] && (|quot[QUOT_W-2:0])))
                      ? {1'b1, {(QUOT_W-1){1'b0}}} : quot[QUOT_W-1:0];

    always_comb
    begin
        if (neg_reg)
        begin
            blend_sum = (INNER_W+3)'(opa_reg) - (INNER_W+3)'({1'b0, quot_sat});
        end
        else
        begin
            blend_sum = (INNER_W+3)'(opa_reg) + (INNER_W+3)'({1'b0, quot_sat});
        end
        if (blend_sum > (INNER_W+3)'(INNER_MAX))
        begin
            blend_res = INNER_MAX;
        end
        else if (blend_sum < (INNER_W+3)'(INNER_MIN))
        begin
            blend_res = INNER_MIN;
        end
        else
        begin
            blend_res = blend_sum[INNER_W-1:0];
        end
        if (blend_res > INNER_W'(coord_t'({1'b0, {(COORD_W-1){1'b1}}})))
        begin
            coord_sat = {1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (blend_res < INNER_W'(coord_t'({1'b1, {(COORD_W-1){1'b0}}})))
        begin
            coord_sat = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            coord_sat = blend_res[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            min_gap_reg    <= CFG_W'(7);
            out_valid_reg  <= 1'b0;
            mul_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            ax_reg         <= '0;
            gi_reg         <= '0;
            k_reg          <= '0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            mul_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                min_gap_reg <= cfg_data;
            end
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (s_tuser[0] == KIND_PUSH)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                for (int j = 0; j < 3; j++)
                                begin
                                    win_reg[i][j] <= win_reg[i][j+1];
                                end
                            end
                            win_reg[0][3] <= s_tdata[31:0];
                            win_reg[1][3] <= s_tdata[63:32];
                            win_reg[2][3] <= s_tdata[95:64];
                        end
                        else
                        begin
                            t_reg     <= s_tdata[111:96];
                            gi_reg    <= '0;
                            ax_reg    <= '0;
                            sumsq_reg <= '0;
                            state_reg <= S_GLD0;
                        end
                    end
                end
                S_GLD0:
                begin
                    opa_reg   <= rd_val;
                    state_reg <= S_GLD1;
                end
                S_GLD1:
                begin
                    mul_a_reg     <= mag;
                    mul_b_reg     <= mag[MUL_B_W-1:0];
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_GSQ;
                end
                S_GSQ:
                begin
                    if (mul_done)
                    begin
                        sumsq_reg <= sumsq_next;
                        if (ax_reg == 2'd2)
                        begin
                            ax_reg         <= '0;
                            rad_reg        <= RAD_W'(sumsq_next);
                            sqrt_start_reg <= 1'b1;
                            state_reg      <= S_GRT1;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= S_GLD0;
                        end
                    end
                end
                S_GRT1:
                begin
                    if (sqrt_done)
                    begin
                        rad_reg        <= RAD_W'({root, 16'h0000});
                        sqrt_start_reg <= 1'b1;
                        state_reg      <= S_GRT2;
                    end
                end
                S_GRT2:
                begin
                    if (sqrt_done)
                    begin
                        gap_reg[gi_reg] <= (root == '0) ? min_gap : root[GAP_W-1:0];
                        sumsq_reg       <= '0;
                        if (gi_reg == 2'd2)
                        begin
                            mul_a_reg     <= MUL_A_W'(gap_reg[1]);
                            mul_b_reg     <= MUL_B_W'(t_reg);
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_OFF;
                        end
                        else
                        begin
                            gi_reg    <= gi_reg + 2'd1;
                            state_reg <= S_GLD0;
                        end
                    end
                end
                S_OFF:
                begin
                    if (mul_done)
                    begin
                        s_reg     <= prod[T_W+GAP_W-1:T_W];
                        ax_reg    <= '0;
                        k_reg     <= '0;
                        state_reg <= S_BLDP;
                    end
                end
                S_BLDP:
                begin
                    opa_reg   <= rd_val;
                    state_reg <= S_BLDQ;
                end
                S_BLDQ:
                begin
                    neg_reg       <= diff[INNER_W];
                    mul_a_reg     <= mag;
                    mul_b_reg     <= MUL_B_W'(num_k);
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_BMUL;
                end
                S_BMUL:
                begin
                    if (mul_done)
                    begin
                        div_num_reg   <= prod[DIVN_W-1:0] + DIVN_W'(den_k >> 1);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_BDIV;
                    end
                end
                S_BDIV:
                begin
                    if (div_done)
                    begin
                        if (k_reg != 3'd5)
                        begin
                            tmp_reg[k_reg] <= blend_res;
                            k_reg          <= k_reg + 3'd1;
                            state_reg      <= S_BLDP;
                        end
                        else
                        begin
                            res_reg[ax_reg] <= coord_sat;
                            k_reg           <= '0;
                            if (ax_reg == 2'd2)
                            begin
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                ax_reg    <= ax_reg + 2'd1;
                                state_reg <= S_BLDP;
                            end
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_data_reg  <= {res_reg[2], res_reg[1], res_reg[0]};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the centripetal Catmull-Rom point evaluator.
// Holds its own window and gap model and compares every evaluate result; needs ccr_pkg and
// centripetal_catmull_rom_eval.
module tb_top;
    import ccr_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [15:0] t;
    } item_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } point_t;

    typedef struct {
        item_t  it;
        logic   fixed;
        point_t want;
    } row_t;

    localparam longint INNER_HI = 64'sd68719476735;
    localparam longint INNER_LO = -64'sd68719476736;
    localparam int     WATCHDOG = 200000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    longint win_x[4];
    longint win_y[4];
    longint win_z[4];
    logic [15:0] gap_floor;
    point_t expected_points[$];
    int errors = 0;
    int evals_seen = 0;
    int pushes_sent = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    row_t rows[$];

    centripetal_catmull_rom_eval DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [63:0] isqrt(logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        r = 0;
        for (int b = 33; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= v)
                r = c;
        end
        return r;
    endfunction

    function automatic logic [63:0] gap_between(int i, int j);
        logic [127:0] acc;
        logic [63:0]  dv;
        logic [63:0]  d;
        logic [63:0]  g;
        longint       diffs[3];
        diffs[0] = win_x[j] - win_x[i];
        diffs[1] = win_y[j] - win_y[i];
        diffs[2] = win_z[j] - win_z[i];
        acc = 0;
        foreach (diffs[k])
        begin
            dv = diffs[k] < 0 ? -diffs[k] : diffs[k];
            acc += 128'(dv) * 128'(dv);
        end
        d = isqrt(acc);
        g = isqrt(128'(d) << 16);
        if (g == 0)
            g = (gap_floor == 0) ? 64'd1 : 64'(gap_floor);
        return g;
    endfunction

    function automatic longint blend(longint p, longint q, logic [63:0] num, logic [63:0] den);
        longint      diff;
        logic [63:0] mag;
        logic [127:0] quot;
        longint      r;
        diff = q - p;
        mag = diff < 0 ? -diff : diff;
        quot = (128'(mag) * 128'(num) + 128'(den / 2)) / 128'(den);
        if (quot > (128'd1 << 38))
            quot = 128'd1 << 38;
        r = diff < 0 ? p - longint'(quot) : p + longint'(quot);
        if (r > INNER_HI) r = INNER_HI;
        if (r < INNER_LO) r = INNER_LO;
        return r;
    endfunction

    function automatic logic [31:0] axis_point(longint w[4], logic [63:0] a, logic [63:0] b,
                                               logic [63:0] c, logic [63:0] s);
        longint a1, a2, a3, b1, b2, r;
        a1 = blend(w[0], w[1], a + s, a);
        a2 = blend(w[1], w[2], s, b);
        a3 = blend(w[3], w[2], c + b - s, c);
        b1 = blend(a1, a2, a + s, a + b);
        b2 = blend(a2, a3, s, b + c);
        r = blend(b1, b2, s, b);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    task automatic apply_item(item_t it, output bit has_point, output point_t p);
        logic [63:0] a, b, c, s;
        has_point = 1'b0;
        p = '0;
        if (it.kind == KIND_PUSH)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_x[i] = win_x[i+1];
                win_y[i] = win_y[i+1];
                win_z[i] = win_z[i+1];
            end
            win_x[3] = longint'(signed'(it.px));
            win_y[3] = longint'(signed'(it.py));
            win_z[3] = longint'(signed'(it.pz));
            return;
        end
        a = gap_between(0, 1);
        b = gap_between(1, 2);
        c = gap_between(2, 3);
        s = (64'(it.t) * b) >> 16;
        p.x = axis_point(win_x, a, b, c, s);
        p.y = axis_point(win_y, a, b, c, s);
        p.z = axis_point(win_z, a, b, c, s);
        has_point = 1'b1;
    endtask

    task automatic send_item(item_t it, bit fixed = 1'b0, point_t want = '0);
        bit     has_point;
        point_t p;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser = it.kind;
        s_tdata = {it.t, it.pz, it.py, it.px};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_item(it, has_point, p);
        if (it.kind == KIND_PUSH)
            pushes_sent++;
        if (has_point)
        begin
            if (fixed && p != want)
            begin
                $display("%0t table row expected %h but model gives %h", $time, want, p);
                errors++;
            end
            expected_points.push_back(p);
        end
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_gap(logic [15:0] v);
        wait (expected_points.size() == 0);
        repeat (3000) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        gap_floor = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(3) << 16;
            3: return 32'(signed'($urandom_range(2000)) - 1000) << 10;
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t push_item(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        item_t it;
        it.kind = KIND_PUSH;
        it.px = x; it.py = y; it.pz = z;
        it.t = $urandom;
        return it;
    endfunction

    function automatic item_t eval_item(logic [15:0] t);
        item_t it;
        it.kind = KIND_EVAL;
        it.px = $urandom; it.py = $urandom; it.pz = $urandom;
        it.t = t;
        return it;
    endfunction

    task automatic random_phase(int n);
        int  k;
        bit  coarse;
        logic [31:0] step;
        k = 0;
        while (k < n)
        begin
            if ($urandom_range(9) < 8)
            begin
                coarse = $urandom_range(1);
                repeat ($urandom_range(4, 1))
                begin
                    if (coarse)
                        send_item(push_item(rand_coord(), rand_coord(), rand_coord()));
                    else
                    begin
                        step = $urandom_range(1) ? 32'h0 : $urandom_range(65535) << 4;
                        send_item(push_item(32'(win_x[3]) + step, 32'(win_y[3]) - step,
                                            32'(win_z[3]) ^ ($urandom & 32'hFFFF)));
                    end
                    k++;
                end
            end
            repeat ($urandom_range(3, 1))
            begin
                send_item(eval_item($urandom_range(2) == 0 ? 16'hFFFF : 16'($urandom)));
                k++;
            end
        end
    endtask

    always @(negedge clk)
        m_tready <= !hold_off &&
                    (recv_stall_pct == 0 || $urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            evals_seen++;
            if (expected_points.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                point_t want;
                want = expected_points.pop_front();
                if (m_tdata[31:0] != want.x)
                begin
                    $display("%0t curve_x expected %h actual %h", $time, want.x, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] != want.y)
                begin
                    $display("%0t curve_y expected %h actual %h", $time, want.y, m_tdata[63:32]);
                    errors++;
                end
                if (m_tdata[95:64] != want.z)
                begin
                    $display("%0t curve_z expected %h actual %h", $time, want.z, m_tdata[95:64]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("Watchdog expired at %0t", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < 4; i++)
        begin
            win_x[i] = 0; win_y[i] = 0; win_z[i] = 0;
        end
        gap_floor = 16'd7;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        rows.push_back('{eval_item(16'h0000), 1'b1, '0});
        rows.push_back('{eval_item(16'hFFFF), 1'b1, '0});
        rows.push_back('{push_item(32'h7FFFFFFF, 32'h80000000, 32'h0), 1'b0, '0});
        rows.push_back('{eval_item(16'h8000), 1'b0, '0});
        rows.push_back('{push_item(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF), 1'b0, '0});
        rows.push_back('{push_item(32'h00010000, 32'h00020000, 32'h00030000), 1'b0, '0});
        rows.push_back('{push_item(32'h00010000, 32'h00020000, 32'h00030000), 1'b0, '0});
        rows.push_back('{eval_item(16'h0000), 1'b0, '0});
        rows.push_back('{eval_item(16'hFFFF), 1'b0, '0});
        rows.push_back('{eval_item(16'h4000), 1'b0, '0});
        for (int i = 0; i < 4; i++)
            rows.push_back('{push_item(32'h00050000, 32'hFFFB0000, 32'h0), 1'b0, '0});
        rows.push_back('{eval_item(16'h0000), 1'b1, '{32'h00050000, 32'hFFFB0000, 32'h0}});
        rows.push_back('{eval_item(16'hFFFF), 1'b1, '{32'h00050000, 32'hFFFB0000, 32'h0}});
        foreach (rows[i])
            send_item(rows[i].it, rows[i].fixed, rows[i].want);

        write_gap(16'd0);
        send_item(eval_item(16'h1234));
        send_item(push_item(32'h00100000, 32'h0, 32'h0));
        send_item(eval_item(16'h7FFF));
        write_gap(16'hFFFF);
        send_item(eval_item(16'h7FFF));
        send_item(eval_item(16'hFFFF));

        write_gap(16'd1);
        random_phase(460);
        write_gap(16'($urandom_range(65535, 1)));
        send_idle_pct = 79;
        random_phase(460);
        send_idle_pct = 0;
        recv_stall_pct = 79;
        random_phase(440);
        write_gap(16'd7);
        send_idle_pct = 16;
        recv_stall_pct = 16;
        random_phase(400);
        send_idle_pct = 0;
        recv_stall_pct = 0;

        fork
            begin
                hold_off = 1'b1;
                repeat (15000) @(negedge clk);
                hold_off = 1'b0;
            end
            random_phase(20);
        join

        wait (expected_points.size() == 0);
        repeat (3000) @(negedge clk);
        $display("Ran %0d pushes and %0d evaluate results under four idle patterns,",
                 pushes_sent, evals_seen);
        $display("with gap register settings 0, 1, 7, 65535 and a random value.");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
